[rtl/fixed_block_pool_allocator_defines.svh]
// Assertion macros for the fixed block pool allocator.
// Included by the RTL modules that carry assertions; depends on nothing.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define FBPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define FBPA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FBPA_ASSERT(label, clk, rst, prop, msg)
`define FBPA_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[rtl/fbpa_pkg.sv]
// Package for the fixed block pool allocator: field widths, register defaults,
// operation, status, register index and sequencer state types. No dependencies.
package fbpa_pkg;

   localparam int unsigned MAX_BLOCKS_DEFAULT = 256;

   localparam int unsigned MODE_W  = 3;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned SIZE_W  = 13;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned OFF_W   = 20;

   localparam logic [SIZE_W-1:0]  SIZE_CAP    = 13'd4096;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd4;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT    = 3'd0,
      MODE_ALLOC   = 3'd1,
      MODE_CALLOC  = 3'd2,
      MODE_FREE    = 3'd3,
      MODE_DESTROY = 3'd4
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_PARAM = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_BLOCK_SIZE  = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

[rtl/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator: free list in a single link memory, small sequencer.
// Depends on fbpa_pkg and fixed_block_pool_allocator_defines.svh.
//
// Usage: each request word on req_* (req_valid / req_stall) carries a mode (init, alloc,
// calloc, free, destroy) and, for free, a block index. Every request gives exactly one
// response word on rsp_* (rsp_valid / rsp_stall): status, grant flag, granted index,
// byte offset (index times block size) and the zero-fill flag for calloc.
// block_size and block_count are written on csr_* (csr_valid / csr_ready, index 0 and 1);
// the user must write them only while no request is in flight; the block does not enforce it.
// Sequence: free, destroy and rejected requests go from accept straight to the done state;
// alloc and calloc pass through a link state for the registered link memory read, which also
// registers the offset multiply. Init walks the link memory one entry a cycle up to the
// block count in use (block_count capped at MAX_BLOCKS) and skips the walk for a count
// of 0. The next request is accepted the cycle after the response is loaded, so the block
// works one request at a time.
// The response sits in an output register: while rsp_stall holds it, the block still
// accepts and works one more request, then waits with it until the register frees.
// Reset (synchronous) empties the free list, clears the pool valid mark and restores
// block_size 4 and block_count 256; link memory contents are left as they are.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [INDEX_W-1:0] req_block_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_granted,
   output logic [INDEX_W-1:0] rsp_granted_index,
   output logic [OFF_W-1:0]   rsp_byte_offset,
   output logic               rsp_zero_fill,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [SIZE_W-1:0]  csr_wdata
);

`include "fixed_block_pool_allocator_defines.svh"

   localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
   localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned PROD_W = IDX_W + SIZE_W;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

   // control registers
   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   block_size_ff;
   logic [COUNT_W-1:0]  block_count_ff;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic                pool_valid_ff, pool_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [LINK_W-1:0]   walk_ff, walk_in;
   logic [IDX_W-1:0]    gidx_ff, gidx_in;
   logic [PROD_W-1:0]   prod_ff;
   status_type          res_status_ff, res_status_in;
   logic                res_granted_ff, res_granted_in;
   logic                res_zero_ff, res_zero_in;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic                rsp_granted_ff;
   logic [INDEX_W-1:0]  rsp_gidx_ff;
   logic [OFF_W-1:0]    rsp_offset_ff;
   logic                rsp_zero_ff;

   // link memory
   logic [LINK_W-1:0]   link_mem [MAX_BLOCKS];
   logic [LINK_W-1:0]   rd_link_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [LINK_W-1:0]   mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic                req_accept;
   logic                out_load;
   logic [LINK_W-1:0]   count_eff;
   logic [SIZE_W-1:0]   size_eff;
   logic                head_null;
   logic [LINK_W-1:0]   walk_next;
   mode_type            mode;

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !reset;
   assign mode       = mode_type'(req_mode);

   // clamp register values into the supported range
   assign count_eff = (32'(block_count_ff) > MAX_BLOCKS) ? LINK_NULL : LINK_W'(block_count_ff);
   assign size_eff  = (block_size_ff > SIZE_CAP) ? SIZE_CAP : block_size_ff;
   assign head_null = (head_ff >= LINK_NULL);
   assign walk_next = walk_ff + LINK_W'(1);
   assign mem_raddr = head_ff[IDX_W-1:0];
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer: next state, list update, memory write port, result staging
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      pool_valid_in  = pool_valid_ff;
      walk_in        = walk_ff;
      gidx_in        = gidx_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_zero_in    = res_zero_ff;
      mem_we         = 1'b0;
      mem_waddr      = walk_ff[IDX_W-1:0];
      mem_wdata      = LINK_NULL;
      rsp_valid_in   = out_load || (rsp_valid_ff && rsp_stall);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_status_in  = STAT_OK;
               res_granted_in = 1'b0;
               res_zero_in    = 1'b0;
               gidx_in        = head_ff[IDX_W-1:0];
               state_in       = ST_DONE;
               unique case (mode) inside
                  MODE_INIT: begin
                     pool_valid_in = 1'b1;
                     walk_in       = '0;
                     if (count_eff == '0) begin
                        head_in = LINK_NULL;
                     end else begin
                        head_in  = '0;
                        state_in = ST_INIT;
                     end
                  end
                  MODE_ALLOC, MODE_CALLOC: begin
                     if (!pool_valid_ff) begin
                        res_status_in = STAT_PARAM;
                     end else if (head_null) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        res_granted_in = 1'b1;
                        res_zero_in    = (mode == MODE_CALLOC);
                        state_in       = ST_LINK;
                     end
                  end
                  MODE_FREE: begin
                     if (req_block_index >= count_eff) begin
                        res_status_in = STAT_PARAM;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(req_block_index);
                        mem_wdata = head_null ? LINK_NULL : head_ff;
                        head_in   = LINK_W'(req_block_index);
                     end
                  end
                  MODE_DESTROY: begin
                     if (!pool_valid_ff) begin
                        res_status_in = STAT_PARAM;
                     end else begin
                        pool_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     res_status_in = STAT_PARAM;
                  end
               endcase
            end
         end
         // chain one entry per cycle: i -> i+1, last -> null
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = (walk_next < count_eff) ? walk_next : LINK_NULL;
            walk_in   = walk_next;
            if (walk_next >= count_eff) begin
               state_in = ST_DONE;
            end
         end
         // pop: head takes the link read at accept
         ST_LINK: begin
            head_in  = (rd_link_ff > LINK_NULL) ? LINK_NULL : rd_link_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= LINK_NULL;
         pool_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         block_size_ff  <= SIZE_RESET;
         block_count_ff <= COUNT_RESET;
      end else begin
         head_ff       <= head_in;
         pool_valid_ff <= pool_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_BLOCK_SIZE:  block_size_ff  <= csr_wdata;
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[COUNT_W-1:0];
               default:         block_size_ff  <= block_size_ff;
            endcase
         end
      end
   end

   // payload registers; offset multiply runs on the head at accept
   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      gidx_ff        <= gidx_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_zero_ff    <= res_zero_in;
      if (req_accept) begin
         prod_ff <= PROD_W'(head_ff[IDX_W-1:0]) * PROD_W'(size_eff);
      end
      if (out_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_zero_ff    <= res_zero_ff;
         rsp_gidx_ff    <= res_granted_ff ? INDEX_W'(gidx_ff) : '0;
         rsp_offset_ff  <= res_granted_ff ? OFF_W'(prod_ff) : '0;
      end
   end

   // link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_link_ff <= link_mem[mem_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_granted_index = rsp_gidx_ff;
   assign rsp_byte_offset   = rsp_offset_ff;
   assign rsp_zero_fill     = rsp_zero_ff;

   // checks
   `FBPA_ASSERT(a_accept_leaves_idle, clock, reset, req_accept |=> state_ff != ST_IDLE, "accepted word did not start the sequencer")
   `FBPA_ASSERT_NEVER(a_head_range, clock, reset, head_ff > LINK_NULL, "free list head out of range")
   `FBPA_ASSERT(a_walk_range, clock, reset, (state_ff == ST_INIT) |-> (walk_ff < count_eff), "init walk passed block count")
   `FBPA_ASSERT(a_grant_ok, clock, reset, (out_load && res_granted_ff) |-> (res_status_ff == STAT_OK), "grant with error status")

endmodule
